// ===== hw/rtl/vn_pkg.sv =====
package vn_pkg;

	// Width of the normalized components and of the length on the result channel.
	localparam int UNIT_W = 32;
	localparam int LEN_W  = 32;

	// Largest component magnitude a result can hold (2^31 - 1).
	localparam logic [63:0] UNIT_MAX = 64'h0000_0000_7FFF_FFFF;
	// Largest length a result can hold (2^32 - 1).
	localparam logic [63:0] LEN_MAX  = 64'h0000_0000_FFFF_FFFF;

	// Control that travels with each divider and square root stage: the stage holds a
	// transaction, plus one bit of side information (a sign or the zero-vector mark).
	typedef struct packed {
		logic valid;
		logic flag;
	} vn_ctl_t;

endpackage

// ===== hw/rtl/vn_in_if.sv =====
interface vn_in_if #(
	parameter int IN_WIDTH = 32
);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] x_in;
	logic signed [IN_WIDTH-1:0] y_in;
	logic signed [IN_WIDTH-1:0] z_in;

	modport source (output valid, output x_in, output y_in, output z_in, input ready);
	modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

// ===== hw/rtl/vn_out_if.sv =====
interface vn_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] unit_x;
	logic signed [31:0] unit_y;
	logic signed [31:0] unit_z;
	logic        [31:0] length;
	logic               was_zero;

	modport source (output valid, output unit_x, output unit_y, output unit_z,
		output length, output was_zero, input ready);
	modport sink   (input valid, input unit_x, input unit_y, input unit_z,
		input length, input was_zero, output ready);
endinterface

// ===== hw/rtl/vn_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, most significant bit first.
// The numerator must not exceed the divisor, so every partial remainder stays below it.
module vn_div import vn_pkg::*; #(
	parameter int DW = 64,
	parameter int QW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  vn_ctl_t       ctl_i,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output vn_ctl_t       ctl_o,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	vn_ctl_t       ctl_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW-1:0] den_p;
		logic [QW-1:0] quo_p;
		vn_ctl_t       ctl_p;
		logic          ge;

		if (k == 0) begin : g_first
			assign trial = {1'b0, num};
			assign den_p = den;
			assign quo_p = '0;
			assign ctl_p = ctl_i;
		end else begin : g_next
			assign trial = {rem_s[k-1], 1'b0};
			assign den_p = den_s[k-1];
			assign quo_p = quo_s[k-1];
			assign ctl_p = ctl_s[k-1];
		end

		assign ge = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_p}) : DW'(trial);
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[QW-2:0], ge};
			end
		end
	end

	assign ctl_o = ctl_s[QW-1];
	assign quo   = quo_s[QW-1];

endmodule

// ===== hw/rtl/vn_isqrt.sv =====
// Integer square root, two radicand bits per stage. Stages past the root width only
// carry the result along, which lets two roots of different widths finish together.
module vn_isqrt import vn_pkg::*; #(
	parameter int IW     = 64,
	parameter int STAGES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  vn_ctl_t          ctl_i,
	input  logic [IW-1:0]    rad,
	output vn_ctl_t          ctl_o,
	output logic [IW/2-1:0]  root
);

	localparam int RB  = IW / 2;
	localparam int RMW = RB + 2;

	logic [RMW-1:0] rem_s  [STAGES];
	logic [RB-1:0]  root_s [STAGES];
	logic [IW-1:0]  rad_s  [STAGES];
	vn_ctl_t        ctl_s  [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [RMW-1:0] rem_p;
		logic [RB-1:0]  root_p;
		logic [IW-1:0]  rad_p;
		vn_ctl_t        ctl_p;
		logic [RMW-1:0] rem_n;
		logic [RB-1:0]  root_n;
		logic [IW-1:0]  rad_n;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign ctl_p  = ctl_i;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign ctl_p  = ctl_s[k-1];
		end

		if (k < RB) begin : g_step
			logic [RMW+1:0] rem_x;
			logic [RMW+1:0] trial;
			logic           ge;

			assign rem_x  = {rem_p, rad_p[IW-1 -: 2]};
			assign trial  = {2'b00, root_p, 2'b01};
			assign ge     = rem_x >= trial;
			assign rem_n  = ge ? RMW'(rem_x - trial) : RMW'(rem_x);
			assign root_n = {root_p[RB-2:0], ge};
			assign rad_n  = {rad_p[IW-3:0], 2'b00};
		end else begin : g_hold
			assign rem_n  = rem_p;
			assign root_n = root_p;
			assign rad_n  = rad_p;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				rad_s[k]  <= rad_n;
			end
		end
	end

	assign ctl_o = ctl_s[STAGES-1];
	assign root  = root_s[STAGES-1];

endmodule

// ===== hw/rtl/vector3_normalize_core.sv =====
// Normalizes one 3D vector per transaction: signed fixed-point components in, unit vector
// components with OUT_FRAC_BITS fractional bits (rounded to nearest, ties away from zero)
// and the truncated Euclidean length out; an all-zero vector returns zeros and was_zero.
// The block is fully pipelined and accepts a new vector every cycle while results are
// taken. The path runs from the magnitude, square and sum-of-squares stages through the
// restoring divider, one quotient bit per stage, and the square root stages, two radicand
// bits each, to the output register.
// A stalled result holds the whole pipeline, so ready follows the result side directly.
module vector3_normalize_core import vn_pkg::*; #(
	parameter int IN_WIDTH      = 32,
	parameter int OUT_FRAC_BITS = 30
) (
	input logic    clk,
	input logic    arst_n,
	vn_in_if.sink  vec,
	vn_out_if.source res
);

	localparam int W   = IN_WIDTH;
	localparam int F   = OUT_FRAC_BITS;
	localparam int SW  = 2 * W;
	localparam int QW  = 2 * F + 3;
	localparam int UIW = QW + 1;
	localparam int URB = UIW / 2;
	localparam int UST = (F + 2 > W - QW) ? F + 2 : W - QW;
	localparam int LST = QW + UST;

	logic en;

	// Stage 1: magnitudes and signs.
	logic [W-1:0] mag_s1 [3];
	logic [2:0]   neg_s1;
	logic         zero_s1;
	logic         v_s1;
	// Stage 2: squares.
	logic [SW-1:0] sq_s2 [3];
	logic [2:0]    neg_s2;
	logic          zero_s2;
	logic          v_s2;
	// Stage 3: sum of squares.
	logic [SW-1:0] sq_s3 [3];
	logic [SW-1:0] sum_s3;
	logic [2:0]    neg_s3;
	logic          zero_s3;
	logic          v_s3;

	logic signed [W-1:0] comp [3];
	logic [W-1:0]        mag  [3];

	assign comp[0] = vec.x_in;
	assign comp[1] = vec.y_in;
	assign comp[2] = vec.z_in;

	for (genvar i = 0; i < 3; i++) begin : g_mag
		assign mag[i] = comp[i][W-1] ? W'(-comp[i]) : W'(comp[i]);
	end

	assign en        = !res.valid || res.ready;
	assign vec.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vec.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag[i];
				neg_s1[i] <= comp[i][W-1];
				sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
				sq_s3[i]  <= sq_s2[i];
			end
			zero_s1 <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Each component: q = floor(c^2 * 2^(2F+2) / S), then twice the unit value is sqrt(q).
	vn_ctl_t        div_ctl [3];
	logic [QW-1:0]  quo     [3];
	vn_ctl_t        urt_ctl [3];
	logic [URB-1:0] twice   [3];

	for (genvar i = 0; i < 3; i++) begin : g_unit
		vn_div #(
			.DW (SW),
			.QW (QW)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  ('{valid: v_s3, flag: neg_s3[i]}),
			.num    (sq_s3[i]),
			.den    (sum_s3),
			.ctl_o  (div_ctl[i]),
			.quo    (quo[i])
		);

		vn_isqrt #(
			.IW     (UIW),
			.STAGES (UST)
		) u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (div_ctl[i]),
			.rad    ({1'b0, quo[i]}),
			.ctl_o  (urt_ctl[i]),
			.root   (twice[i])
		);
	end

	vn_ctl_t      len_ctl;
	logic [W-1:0] len_root;

	vn_isqrt #(
		.IW     (SW),
		.STAGES (LST)
	) u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  ('{valid: v_s3, flag: zero_s3}),
		.rad    (sum_s3),
		.ctl_o  (len_ctl),
		.root   (len_root)
	);

	function automatic logic [UNIT_W-1:0] round_unit(input logic [URB-1:0] tw,
		input logic neg);
		logic [63:0]       half;
		logic [UNIT_W-2:0] m;
		logic [UNIT_W-1:0] u;
		half = (64'(tw) + 64'd1) >> 1;
		m    = (half > UNIT_MAX) ? UNIT_MAX[UNIT_W-2:0] : half[UNIT_W-2:0];
		u    = {1'b0, m};
		return neg ? UNIT_W'(-u) : u;
	endfunction

	logic [63:0] len_wide;
	assign len_wide = 64'(len_root);

	logic               out_v_q;
	logic [UNIT_W-1:0]  unit_q [3];
	logic [LEN_W-1:0]   len_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= len_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit_q[i] <= len_ctl.flag ? '0 : round_unit(twice[i], urt_ctl[i].flag);
			end
			len_q  <= (len_wide > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : len_wide[LEN_W-1:0];
			zero_q <= len_ctl.flag;
		end
	end

	assign res.valid    = out_v_q;
	assign res.unit_x   = unit_q[0];
	assign res.unit_y   = unit_q[1];
	assign res.unit_z   = unit_q[2];
	assign res.length   = len_q;
	assign res.was_zero = zero_q;

endmodule

// ===== hw/rtl/vn_checker.sv =====
module vn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] unit_x,
	input logic [31:0] unit_y,
	input logic [31:0] unit_z,
	input logic [31:0] length,
	input logic        was_zero
);

	// A result that is not taken stays on the port.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(length) && $stable(unit_x))
		else $error("result changed while stalled");

	// With no result waiting the pipeline must take input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// The zero vector reports zeros everywhere.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_zero |->
			unit_x == 32'd0 && unit_y == 32'd0 && unit_z == 32'd0 && length == 32'd0)
		else $error("zero vector gave a nonzero result");

	// Any nonzero vector has a length of at least one input code.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !was_zero |-> length != 32'd0)
		else $error("nonzero vector gave zero length");

	// Saturation is symmetric, so the most negative code never appears.
	a_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			unit_x != 32'h8000_0000 && unit_y != 32'h8000_0000 && unit_z != 32'h8000_0000)
		else $error("unit component hit the most negative code");

endmodule

bind vector3_normalize_core vn_checker u_vn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (vec.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.unit_x    (res.unit_x),
	.unit_y    (res.unit_y),
	.unit_z    (res.unit_z),
	.length    (res.length),
	.was_zero  (res.was_zero)
);
